// ----- design/bet_pkg.sv -----
// Shared types, constants and saturating fixed-point helpers for the escape-time block.
package bet_pkg;
  localparam int COUNT_BITS = 12;
  localparam int FRAC_BITS = 28;
  localparam int DP_W = 40;
  localparam int DP_FRAC = 30;
  localparam int IN_SHIFT = DP_FRAC - FRAC_BITS;
  localparam int CLR_W = 13;

  typedef logic signed [DP_W-1:0] dp_t;

  localparam dp_t DP_MAX = {1'b0, {(DP_W-1){1'b1}}};
  localparam dp_t DP_MIN = {1'b1, {(DP_W-1){1'b0}}};
  localparam dp_t ESCAPE_SQ = dp_t'(64'sd10 <<< DP_FRAC);
  localparam dp_t K27 = dp_t'(64'sd27 <<< DP_FRAC);

  localparam logic [1:0] CFG_D_REAL = 2'd0;
  localparam logic [1:0] CFG_D_IMAG = 2'd1;
  localparam logic [1:0] CFG_MAX_IT = 2'd2;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  localparam logic [1:0] OUT_ESCAPED = 2'd0;
  localparam logic [1:0] OUT_BOUNDED = 2'd1;
  localparam logic [1:0] OUT_DISC = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_PREP, ST_START, ST_INIT_RE2, ST_INIT_IM2, ST_TEST,
    ST_M1, ST_M1W, ST_M2, ST_M3, ST_STEP_END,
    ST_D1, ST_D2, ST_D3, ST_D4, ST_D5, ST_DSUM,
    ST_RUN_END, ST_OUT
  } state_t;

  typedef struct packed {
    logic go;
    dp_t a;
    dp_t b;
  } mul_req_t;

  function automatic dp_t sat_w(input logic signed [47:0] v);
    if (v > 48'(DP_MAX)) return DP_MAX;
    if (v < 48'(DP_MIN)) return DP_MIN;
    return v[DP_W-1:0];
  endfunction

  function automatic dp_t sadd(input dp_t a, input dp_t b);
    return sat_w(48'(a) + 48'(b));
  endfunction

  function automatic dp_t ssub(input dp_t a, input dp_t b);
    return sat_w(48'(a) - 48'(b));
  endfunction

  function automatic dp_t sscale(input dp_t a, input logic signed [9:0] k);
    logic signed [55:0] p;
    p = 56'(a) * 56'(k);
    if (p > 56'(DP_MAX)) return DP_MAX;
    if (p < 56'(DP_MIN)) return DP_MIN;
    return p[DP_W-1:0];
  endfunction
endpackage

// ----- design/biquadratic_escape_time.sv -----
// Top level: escape-time classifier with sequencer, registers and shared multiplier.
//   channel | signals                          | direction
//   in      | in_valid/in_ready, c_real/c_imag | into block
//   out     | out_valid/out_ready, outcome/idx | out of block
//   cfg     | cfg_we, cfg_index, cfg_data      | into block
// Each multiply holds the sequencer until its result is done on the one shared multiplier;
// an iteration uses six of them plus the add and test steps, and the discriminant test
// runs as well when d is zero.
// Reset is synchronous and active low; no input item is taken while one is in work
// or while a result waits in the output register.
module biquadratic_escape_time (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_c_real,
  input  logic [31:0] in_c_imag,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_outcome,
  output logic [12:0] out_color_index,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  bet_pkg::state_t st_r, st_nxt;
  logic signed [31:0] dre_r, dim_r;
  logic [11:0] maxit_r;
  bet_pkg::dp_t cr_r, ci_r, are_r, aim_r, bre_r, bim_r;
  bet_pkg::dp_t re_r, im_r, re2_r, im2_r, t_r;
  bet_pkg::dp_t re_nxt, im_nxt, re2_nxt, im2_nxt, t_nxt;
  logic [bet_pkg::COUNT_BITS-1:0] n_r, n_nxt, j_r, j_nxt, lim_r;
  logic run2_r, run2_nxt, half_r, half_nxt;
  logic [1:0] oc_r, oc_nxt;
  logic [12:0] ci_out_r, ci_out_nxt;
  logic ov_r, ov_nxt;
  bet_pkg::mul_req_t req;
  logic mdone;
  bet_pkg::dp_t prod;
  bet_pkg::dp_t cr_in, ci_in, dr, di;
  bet_pkg::dp_t sq_sum;
  logic [bet_pkg::COUNT_BITS-1:0] ii;

  assign cr_in = bet_pkg::sat_w(48'($signed(in_c_real)) <<< bet_pkg::IN_SHIFT);
  assign ci_in = bet_pkg::sat_w(48'($signed(in_c_imag)) <<< bet_pkg::IN_SHIFT);
  assign dr = bet_pkg::sat_w(48'(dre_r) <<< bet_pkg::IN_SHIFT);
  assign di = bet_pkg::sat_w(48'(dim_r) <<< bet_pkg::IN_SHIFT);
  assign sq_sum = bet_pkg::sadd(re2_r, im2_r);
  assign ii = n_r;

  bet_mul u_mul (.clk(clk), .rst_n(rst_n), .req(req), .done(mdone), .prod(prod));

  assign in_ready = (st_r == bet_pkg::ST_IDLE) && !ov_r;
  assign out_valid = ov_r;
  assign out_outcome = oc_r;
  assign out_color_index = ci_out_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      bet_pkg::ST_IDLE: if (in_valid && in_ready) st_nxt = bet_pkg::ST_PREP;
      bet_pkg::ST_PREP: st_nxt = bet_pkg::ST_START;
      bet_pkg::ST_START: st_nxt = bet_pkg::ST_INIT_RE2;
      bet_pkg::ST_INIT_RE2: if (mdone) st_nxt = bet_pkg::ST_INIT_IM2;
      bet_pkg::ST_INIT_IM2: if (mdone) st_nxt = bet_pkg::ST_TEST;
      bet_pkg::ST_TEST:
        if (n_r < lim_r && sq_sum < bet_pkg::ESCAPE_SQ) st_nxt = bet_pkg::ST_M1;
        else st_nxt = bet_pkg::ST_RUN_END;
      bet_pkg::ST_M1: if (mdone) st_nxt = bet_pkg::ST_M1W;
      bet_pkg::ST_M1W: st_nxt = bet_pkg::ST_M2;
      bet_pkg::ST_M2: if (mdone) st_nxt = bet_pkg::ST_M3;
      bet_pkg::ST_M3: if (mdone) st_nxt = half_r ? bet_pkg::ST_STEP_END : bet_pkg::ST_M1;
      bet_pkg::ST_STEP_END: st_nxt = bet_pkg::ST_TEST;
      bet_pkg::ST_RUN_END:
        if (run2_r) st_nxt = bet_pkg::ST_OUT;
        else if (dre_r == '0 && dim_r == '0) st_nxt = bet_pkg::ST_D1;
        else st_nxt = bet_pkg::ST_START;
      bet_pkg::ST_D1: if (mdone) st_nxt = bet_pkg::ST_D2;
      bet_pkg::ST_D2: if (mdone) st_nxt = bet_pkg::ST_D3;
      bet_pkg::ST_D3: if (mdone) st_nxt = bet_pkg::ST_D4;
      bet_pkg::ST_D4: if (mdone) st_nxt = bet_pkg::ST_D5;
      bet_pkg::ST_D5: if (mdone) st_nxt = bet_pkg::ST_DSUM;
      bet_pkg::ST_DSUM: st_nxt = t_nxt[39] ? bet_pkg::ST_IDLE : bet_pkg::ST_START;
      bet_pkg::ST_OUT: st_nxt = bet_pkg::ST_IDLE;
      default: st_nxt = bet_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operand select and launch; a request fires on entry to each step.
  always_comb begin
    req = '0;
    unique case (st_nxt)
      bet_pkg::ST_INIT_RE2: begin req.a = re_nxt; req.b = re_nxt; end
      bet_pkg::ST_INIT_IM2: begin req.a = im_nxt; req.b = im_nxt; end
      bet_pkg::ST_M1: begin req.a = re_nxt; req.b = im_nxt; end
      bet_pkg::ST_M2: begin req.a = re_nxt; req.b = re_nxt; end
      bet_pkg::ST_M3: begin req.a = im_nxt; req.b = im_nxt; end
      bet_pkg::ST_D1: begin req.a = cr_r; req.b = cr_r; end
      bet_pkg::ST_D2: begin req.a = ci_r; req.b = ci_r; end
      bet_pkg::ST_D3: begin req.a = re2_nxt; req.b = cr_r; end
      bet_pkg::ST_D4: begin req.a = cr_r; req.b = im2_nxt; end
      bet_pkg::ST_D5: begin req.a = t_nxt; req.b = t_nxt; end
      default: ;
    endcase
    req.go = (st_nxt != st_r || mdone) &&
             (st_nxt == bet_pkg::ST_INIT_RE2 || st_nxt == bet_pkg::ST_INIT_IM2 ||
              st_nxt == bet_pkg::ST_M1 || st_nxt == bet_pkg::ST_M2 ||
              st_nxt == bet_pkg::ST_M3 || st_nxt == bet_pkg::ST_D1 ||
              st_nxt == bet_pkg::ST_D2 || st_nxt == bet_pkg::ST_D3 ||
              st_nxt == bet_pkg::ST_D4 || st_nxt == bet_pkg::ST_D5) &&
             !(st_r == bet_pkg::ST_M1 && st_nxt == bet_pkg::ST_M1 && !mdone);
  end

  always_comb begin
    re_nxt = re_r; im_nxt = im_r; re2_nxt = re2_r; im2_nxt = im2_r; t_nxt = t_r;
    n_nxt = n_r; j_nxt = j_r; run2_nxt = run2_r; half_nxt = half_r;
    oc_nxt = oc_r; ci_out_nxt = ci_out_r; ov_nxt = ov_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (st_r)
      bet_pkg::ST_IDLE: run2_nxt = 1'b0;
      bet_pkg::ST_START: begin
        re_nxt = run2_r ? bre_r : '0;
        im_nxt = run2_r ? bim_r : '0;
        n_nxt = '0;
      end
      bet_pkg::ST_INIT_RE2: if (mdone) re2_nxt = prod;
      bet_pkg::ST_INIT_IM2: if (mdone) im2_nxt = prod;
      bet_pkg::ST_TEST: half_nxt = 1'b0;
      bet_pkg::ST_M1: if (mdone) t_nxt = prod;
      bet_pkg::ST_M1W: begin
        im_nxt = bet_pkg::sadd(bet_pkg::sscale(t_r, 10'sd2), half_r ? bim_r : aim_r);
        re_nxt = bet_pkg::sadd(bet_pkg::ssub(re2_r, im2_r), half_r ? bre_r : are_r);
      end
      bet_pkg::ST_M2: if (mdone) re2_nxt = prod;
      bet_pkg::ST_M3: if (mdone) begin
        im2_nxt = prod;
        half_nxt = 1'b1;
      end
      bet_pkg::ST_STEP_END: n_nxt = n_r + 1'b1;
      bet_pkg::ST_RUN_END: begin
        if (!run2_r) j_nxt = n_r;
        run2_nxt = 1'b1;
      end
      bet_pkg::ST_D1: if (mdone) re2_nxt = prod;
      bet_pkg::ST_D2: if (mdone) begin
        im2_nxt = prod;
        t_nxt = bet_pkg::sadd(re2_r, prod);
      end
      bet_pkg::ST_D3: if (mdone) re_nxt = prod;
      bet_pkg::ST_D4: if (mdone) re_nxt = bet_pkg::ssub(re_r, bet_pkg::sscale(prod, 10'sd3));
      bet_pkg::ST_D5: if (mdone) im_nxt = prod;
      bet_pkg::ST_DSUM: begin
        t_nxt = bet_pkg::ssub(bet_pkg::sadd(
                  bet_pkg::sscale(bet_pkg::sadd(im_r, bet_pkg::sscale(re_r, 10'sd2)),
                                  10'sd256),
                  bet_pkg::sscale(t_r, 10'sd288)), bet_pkg::K27);
        if (t_nxt[39]) begin
          oc_nxt = bet_pkg::OUT_DISC; ci_out_nxt = '0; ov_nxt = 1'b1;
        end
      end
      bet_pkg::ST_OUT: begin
        ov_nxt = 1'b1;
        if (ii >= lim_r && j_r >= lim_r) begin
          oc_nxt = bet_pkg::OUT_BOUNDED; ci_out_nxt = '0;
        end else begin
          oc_nxt = bet_pkg::OUT_ESCAPED;
          ci_out_nxt = (ii < j_r) ? 13'({1'b0, j_r} << 1) : 13'({1'b0, ii, 1'b1});
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= bet_pkg::ST_IDLE;
      ov_r <= 1'b0;
      dre_r <= '0;
      dim_r <= '0;
      maxit_r <= 12'd100;
      run2_r <= 1'b0;
      half_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      run2_r <= run2_nxt;
      half_r <= half_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bet_pkg::CFG_D_REAL: dre_r <= cfg_data;
          bet_pkg::CFG_D_IMAG: dim_r <= cfg_data;
          bet_pkg::CFG_MAX_IT: maxit_r <= cfg_data[11:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == bet_pkg::ST_IDLE && in_valid && in_ready) begin
      cr_r <= cr_in;
      ci_r <= ci_in;
    end
    if (st_r == bet_pkg::ST_PREP) begin
      are_r <= bet_pkg::sadd(cr_r, dr);
      aim_r <= bet_pkg::sadd(ci_r, di);
      bre_r <= bet_pkg::sadd(cr_r, bet_pkg::sscale(dr, 10'sd2));
      bim_r <= bet_pkg::sadd(bet_pkg::sat_w(-48'(ci_r)), bet_pkg::sscale(di, 10'sd2));
      lim_r <= bet_pkg::COUNT_BITS'(maxit_r);
    end
    re_r <= re_nxt; im_r <= im_nxt; re2_r <= re2_nxt; im2_r <= im2_nxt; t_r <= t_nxt;
    n_r <= n_nxt; j_r <= j_nxt; oc_r <= oc_nxt; ci_out_r <= ci_out_nxt;
  end
endmodule

// ----- design/bet_mul.sv -----
// Shared Q9.30 multiplier: two 40x20 partial products, one per cycle, then saturation.
module bet_mul (
  input  logic              clk,
  input  logic              rst_n,
  input  bet_pkg::mul_req_t req,
  output logic              done,
  output bet_pkg::dp_t      prod
);
  logic [1:0] ph_r, ph_nxt;
  logic neg_r, neg_nxt;
  logic [40:0] ma_r, ma_nxt, mb_r, mb_nxt;
  logic [81:0] acc_r, acc_nxt;
  logic [60:0] pp;
  logic [71:0] mag;
  logic [40:0] lim;
  bet_pkg::dp_t res;

  assign pp = ma_r * (ph_r == 2'd1 ? mb_r[19:0] : mb_r[39:20]);

  always_comb begin
    ph_nxt = ph_r;
    neg_nxt = neg_r;
    ma_nxt = ma_r;
    mb_nxt = mb_r;
    acc_nxt = acc_r;
    if (req.go) begin
      ph_nxt = 2'd1;
      neg_nxt = req.a[39] ^ req.b[39];
      ma_nxt = req.a[39] ? 41'(-42'(req.a)) : 41'(req.a);
      mb_nxt = req.b[39] ? 41'(-42'(req.b)) : 41'(req.b);
      acc_nxt = '0;
    end else if (ph_r == 2'd1) begin
      ph_nxt = 2'd2;
      acc_nxt = 82'(pp);
    end else if (ph_r == 2'd2) begin
      ph_nxt = 2'd3;
      acc_nxt = acc_r + (82'(pp) << 20) + (82'(ma_r * mb_r[40]) << 40);
    end else if (ph_r == 2'd3) begin
      ph_nxt = 2'd0;
    end
  end

  always_comb begin
    mag = 72'(acc_r >> 30);
    lim = (mag > 72'(41'h100_0000_0000)) ? 41'h100_0000_0000 : mag[40:0];
    if (neg_r) res = (lim >= 41'h080_0000_0000) ? bet_pkg::DP_MIN
                   : bet_pkg::dp_t'(-42'(lim));
    else res = (lim > 41'(bet_pkg::DP_MAX)) ? bet_pkg::DP_MAX : bet_pkg::dp_t'(lim);
  end

  assign done = (ph_r == 2'd3);
  assign prod = res;

  always_ff @(posedge clk) begin
    if (!rst_n) ph_r <= 2'd0;
    else ph_r <= ph_nxt;
    neg_r <= neg_nxt;
    ma_r <= ma_nxt;
    mb_r <= mb_nxt;
    acc_r <= acc_nxt;
  end
endmodule

// ----- design/bet_check.sv -----
// Port-level checker for the escape-time block, bound to the top level.
module bet_check (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_outcome,
  input logic [12:0] out_color_index
);
  a_no_in_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_outcome == bet_pkg::OUT_ESCAPED ||
                   out_outcome == bet_pkg::OUT_BOUNDED ||
                   out_outcome == bet_pkg::OUT_DISC)) else $error("bad outcome code");
  a_zero_color: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_outcome != bet_pkg::OUT_ESCAPED) |-> out_color_index == '0)
    else $error("color index set without escape");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready right after accept");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid && $stable(out_outcome))
    else $error("result dropped");
endmodule

bind biquadratic_escape_time bet_check u_bet_check (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_outcome(out_outcome),
  .out_color_index(out_color_index)
);
